### hw/rtl/wfpa_pkg.sv
package wfpa_pkg;

    // table geometry
    localparam int MAX_PARTS = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int SIZE_W    = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_PARTS);

    // function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  part_index;
        logic [SIZE_W-1:0] size_value;
    } in_word_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] granted_index;
    } out_word_t;

    // size table access from the scan engine
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [SIZE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

### hw/rtl/wfpa_size_mem.sv
module wfpa_size_mem
    import wfpa_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [SIZE_W-1:0] rdata
);

    logic [SIZE_W-1:0] mem [MAX_PARTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

### hw/rtl/wfpa_scan.sv
module wfpa_scan
    import wfpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    input  logic [CNT_W-1:0]  count,
    output mem_req_t          mreq,
    input  logic [SIZE_W-1:0] rdata,
    output logic              done,
    output out_word_t         result,
    input  logic              take
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [SIZE_W-1:0]   req_reg, req_next;
    logic                chk_vld_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                have_reg, have_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]   best_size_reg, best_size_next;
    logic [MAX_PARTS-1:0] used_reg, used_next;
    logic                in_acc;
    logic                fit;
    logic                better;
    logic [CNT_W-1:0]    clamped;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign clamped  = (count > CNT_W'(MAX_PARTS)) ? CNT_W'(MAX_PARTS) : count;

    // size table access: loads write, scan reads one entry a cycle
    always_comb
    begin
        mreq.we    = in_acc && (in_data.func == FUNC_LOAD);
        mreq.waddr = in_data.part_index;
        mreq.wdata = in_data.size_value;
        mreq.re    = (state_reg == ST_SCAN) && (rd_cnt_reg < limit_reg);
        mreq.raddr = rd_cnt_reg[IDX_W-1:0];
    end

    // candidate check on the word just read
    assign fit    = !used_reg[chk_idx_reg] && (rdata >= req_reg);
    assign better = fit && (!have_reg || (rdata > best_size_reg));

    assign done                 = (state_reg == ST_FINISH);
    assign result.found         = have_reg;
    assign result.granted_index = have_reg ? best_idx_reg : '0;

    // control
    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        rd_cnt_next    = rd_cnt_reg;
        req_next       = req_reg;
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        used_next      = used_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.func == FUNC_LOAD)
                    begin
                        used_next[in_data.part_index] = 1'b0;
                    end
                    else
                    begin
                        req_next    = in_data.size_value;
                        limit_next  = clamped;
                        rd_cnt_next = '0;
                        have_next   = 1'b0;
                        state_next  = (clamped == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (mreq.re)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (chk_vld_reg && better)
                begin
                    have_next      = 1'b1;
                    best_idx_next  = chk_idx_reg;
                    best_size_next = rdata;
                end
                if (!mreq.re && !chk_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    if (have_reg)
                    begin
                        used_next[best_idx_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            chk_vld_reg <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            chk_vld_reg <= mreq.re;
            have_reg    <= have_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        rd_cnt_reg    <= rd_cnt_next;
        req_reg       <= req_next;
        chk_idx_reg   <= mreq.raddr;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
    end

    // checks
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> (state_reg == ST_IDLE))
        else $error("size table written outside idle");

    a_chk_range: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> ({1'b0, chk_idx_reg} < limit_reg))
        else $error("checked entry beyond scan limit");

    a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done && take && result.found) |-> !used_reg[result.granted_index])
        else $error("granted partition already used");

    a_grant_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (done && take && result.found) |=> used_reg[$past(result.granted_index)])
        else $error("granted partition not marked used");

endmodule

### hw/rtl/worst_fit_partition_allocator.sv
// Worst-fit partition allocator; count = partition_count capped at 16.
// Load word: gives no result; the next word can be taken the cycle after.
// Allocate word: the scan reads one size table entry per cycle, entries 0 to count-1, checks
// each one as it is read back, then loads the result register (no scan when count is 0).
// No new word is taken until the result has been loaded; a result left waiting stalls input.
// Reset (rst_n, async, active low) frees every partition, sets partition_count to 16.
module worst_fit_partition_allocator
    import wfpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    logic [CNT_W-1:0]  count_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;
    mem_req_t          mreq;
    logic [SIZE_W-1:0] rdata;
    logic              done;
    out_word_t         result;
    logic              take;

    assign cfg_ready = 1'b1;
    assign take      = done && (!out_valid_reg || out_ready);

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    wfpa_size_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    wfpa_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .count    (count_reg),
        .mreq     (mreq),
        .rdata    (rdata),
        .done     (done),
        .result   (result),
        .take     (take)
    );

endmodule
